@@ rtl/core/sitoa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the signed integer to decimal ASCII formatter.
// Used by the controller, the datapath and the top level; depends on nothing.

package sitoa_pkg;

	localparam int unsigned NUM_DIGITS    = 10;
	localparam int unsigned VALUE_WIDTH   = 32;
	localparam int unsigned BITS_PER_STEP = 8;
	localparam int unsigned CONV_STEPS    = VALUE_WIDTH / BITS_PER_STEP;
	localparam int unsigned CNT_WIDTH     = $clog2(CONV_STEPS);
	localparam int unsigned IDX_WIDTH     = $clog2(NUM_DIGITS);

	localparam logic [7:0] DIGIT_BASE = 8'd48;
	localparam logic [7:0] MINUS_CHAR = 8'd45;
	localparam logic [7:0] DIGIT_NINE = 8'd57;

	typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic conv_step;
		logic set_idx;
		logic push_sign;
		logic push_digit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic conv_last;
		logic negative;
		logic idx_zero;
		logic out_free;
	} status_t;

endpackage

@@ rtl/core/sitoa_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine for the decimal formatter: sequences load,
// conversion and character emission. Depends on sitoa_pkg.

module sitoa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  sitoa_pkg::status_t status,
	output sitoa_pkg::cmd_t    cmd
);
	import sitoa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (status.conv_last) begin
					state_d = ST_SIGN;
				end
			end
			ST_SIGN: begin
				cmd.set_idx = 1'b1;
				// A non-negative value moves on at once; a negative one waits for room.
				if (!status.negative) begin
					state_d = ST_DIGIT;
				end else if (status.out_free) begin
					cmd.push_sign = 1'b1;
					state_d       = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (status.out_free) begin
					cmd.push_digit = 1'b1;
					if (status.idx_zero) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/sitoa_dp.sv @@
`timescale 1ns / 1ps
// Datapath for the decimal formatter: magnitude register, shift-and-add-3
// BCD converter, digit pointer and output register. Depends on sitoa_pkg.

module sitoa_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] value,
	input  sitoa_pkg::cmd_t    cmd,
	output sitoa_pkg::status_t status,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         character,
	output logic               last
);
	import sitoa_pkg::*;

	logic [VALUE_WIDTH-1:0] bin_q;
	bcd_t                   bcd_q;
	logic                   neg_q;
	logic [CNT_WIDTH-1:0]   cnt_q;
	logic [IDX_WIDTH-1:0]   idx_q;
	logic                   valid_q;
	logic [7:0]             char_q;
	logic                   last_q;

	bcd_t                   bcd_next;
	logic [VALUE_WIDTH-1:0] bin_next;
	logic [IDX_WIDTH-1:0]   msd;
	logic [VALUE_WIDTH-1:0] mag;

	assign mag = value[31] ? (~value + 32'd1) : value;

	// Eight bits of the magnitude enter the BCD register per step.
	always_comb begin
		bcd_t                   b;
		logic [VALUE_WIDTH-1:0] w;
		logic [4*NUM_DIGITS-1:0] flat;
		b = bcd_q;
		w = bin_q;
		for (int s = 0; s < BITS_PER_STEP; s++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (b[d] >= 4'd5) begin
					b[d] = b[d] + 4'd3;
				end
			end
			flat = b;
			flat = {flat[4*NUM_DIGITS-2:0], w[VALUE_WIDTH-1]};
			b    = flat;
			w    = {w[VALUE_WIDTH-2:0], 1'b0};
		end
		bcd_next = b;
		bin_next = w;
	end

	// Highest non-zero digit, or the units digit when the value is zero.
	always_comb begin
		msd = '0;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (bcd_q[d] != 4'd0) begin
				msd = IDX_WIDTH'(d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.conv_step) begin
				cnt_q <= cnt_q + CNT_WIDTH'(1);
			end
			if (cmd.push_sign || cmd.push_digit) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= mag;
			bcd_q <= '0;
			neg_q <= value[31];
		end else if (cmd.conv_step) begin
			bin_q <= bin_next;
			bcd_q <= bcd_next;
		end
		if (cmd.set_idx) begin
			idx_q <= msd;
		end else if (cmd.push_digit) begin
			idx_q <= idx_q - IDX_WIDTH'(1);
		end
		if (cmd.push_sign) begin
			char_q <= MINUS_CHAR;
			last_q <= 1'b0;
		end else if (cmd.push_digit) begin
			char_q <= DIGIT_BASE + {4'b0000, bcd_q[idx_q]};
			last_q <= (idx_q == '0);
		end
	end

	assign status.conv_last = (cnt_q == CNT_WIDTH'(CONV_STEPS - 1));
	assign status.negative  = neg_q;
	assign status.idx_zero  = (idx_q == '0);
	assign status.out_free  = !valid_q || !out_stall;

	assign out_valid = valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

@@ rtl/core/signed_int_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
// Signed 32-bit integer to decimal ASCII formatter, top level.
// Joins sitoa_ctrl and sitoa_dp; depends on sitoa_pkg.
//
// Usage: a request on the input channel (in_valid, in_stall, value) carries
// one two's complement integer. The output channel (out_valid, out_stall,
// character, last) returns its decimal text one ASCII character per request,
// most significant digit first, with a leading '-' for negative values and
// last set on the final digit. Zero gives a single '0'.
// Timing: acceptance is followed by the conversion in the shift-and-add-3
// unit (eight bits a cycle), the sign state, and then the digits, one per
// cycle while the output is not stalled. in_stall stays high from acceptance
// until the last digit has been loaded into the output register, so the next
// value can be taken while that character still waits. When out_stall is
// high a full output register holds and the sequencer waits before it emits
// another character. Reset empties the output register and returns the
// controller to idle; no clearing pass is needed.

module signed_int_to_decimal_ascii (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         character,
	output logic               last
);
	import sitoa_pkg::*;

	cmd_t    cmd;
	status_t status;

	sitoa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	sitoa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

	// The block is busy in the cycle after it takes a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a conversion was starting");

	// Only a minus sign or a decimal digit ever leaves.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character == MINUS_CHAR) ||
			((character >= DIGIT_BASE) && (character <= DIGIT_NINE)))
		else $error("output character is neither a sign nor a digit");

	// A minus sign never ends a run.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (character == MINUS_CHAR) |-> !last)
		else $error("minus sign marked as last character");

	// A new value is taken only when no character is being produced.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(cmd.push_sign || cmd.push_digit))
		else $error("load issued together with a character push");

endmodule

@@ tb/signed_int_to_decimal_ascii_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for signed_int_to_decimal_ascii: predicts the text of every
// accepted integer and compares each character and last flag. Depends on sitoa_pkg.

module signed_int_to_decimal_ascii_test;
	import sitoa_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 200;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic [7:0] code;
		logic       fin;
	} ascii_char_t;

	class ascii_scoreboard;
		ascii_char_t expected_chars[$];
		int          errors;

		function new();
			errors = 0;
		endfunction

		// Works out the decimal text of one accepted request.
		function void note_value(logic [31:0] word);
			logic [31:0] mag;
			logic [31:0] rem;
			logic [7:0]  digits [0:9];
			ascii_char_t ch;
			int          n;
			int          i;
			n = 0;
			// The magnitude is taken as unsigned, so the most negative value needs no special path.
			mag = word[31] ? (~word + 32'd1) : word;
			do begin
				rem = mag % 32'd10;
				digits[n] = DIGIT_BASE + rem[7:0];
				mag = mag / 32'd10;
				n++;
			end while (mag != 32'd0 && n < NUM_DIGITS);
			if (word[31]) begin
				ch.code = MINUS_CHAR;
				ch.fin = 1'b0;
				expected_chars.push_back(ch);
			end
			for (i = n - 1; i >= 0; i--) begin
				ch.code = digits[i];
				ch.fin = (i == 0);
				expected_chars.push_back(ch);
			end
		endfunction

		function void check_char(logic [7:0] code, logic fin);
			ascii_char_t want;
			if (expected_chars.size() == 0) begin
				$error("character %0d (last %0b) arrived with nothing expected", code, fin);
				errors++;
				return;
			end
			want = expected_chars.pop_front();
			if (want.code !== code) begin
				$error("character: expected %0d, got %0d", want.code, code);
				errors++;
			end
			if (want.fin !== fin) begin
				$error("last: expected %0b, got %0b", want.fin, fin);
				errors++;
			end
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic signed [31:0] value    = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        character;
	logic              last;

	ascii_scoreboard sb = new();
	int  idle_pct    = 0;
	int  stall_pct   = 0;
	logic hold_req   = 1'b0;
	logic hold_taken = 1'b0;
	int  hold_left   = 0;
	int  cycle_count = 0;

	logic [31:0] directed_values [0:19] = '{
		32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
		32'h7FFFFFFF, 32'h80000000, 32'h80000001, 32'd1000000000, 32'd999999999,
		-32'sd999999999, 32'd1000000009, 32'd123456789, -32'sd5, 32'd5,
		32'h55555555, 32'hAAAAAAAA
	};

	signed_int_to_decimal_ascii u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("signed_int_to_decimal_ascii test failed");
			$finish;
		end
	end

	// Receiver: random stalls, and one long hold-off when asked so that the block backs up.
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_value(value);
		if (arst_n && out_valid && !out_stall)
			sb.check_char(character, last);
	end

	// Random gap, then offer the request and hold it until the block takes it.
	task automatic send_value(input logic [31:0] v);
		int idle;
		idle = 0;
		while (idle < 40 && $urandom_range(99) < idle_pct)
			idle++;
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// Mostly values of a chosen digit count, so that every run length turns up often.
	function automatic logic [31:0] random_value();
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] m;
		int          n;
		if ($urandom_range(7) == 0)
			return $urandom;
		n = $urandom_range(10, 1);
		lo = 32'd1;
		repeat (n - 1) lo = lo * 32'd10;
		hi = (n == 10) ? 32'd2147483647 : lo * 32'd10 - 32'd1;
		if (n == 1)
			lo = 32'd0;
		m = $urandom_range(hi, lo);
		if ($urandom_range(1))
			m = -m;
		return m;
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_values[i])
			send_value(directed_values[i]);
		wait_drained();

		// The sender keeps offering while the output is held, so the input must stall.
		hold_req <= 1'b1;
		repeat (16) send_value(random_value());
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 76;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 76;
				end
				default: begin
					idle_pct = 6;
					stall_pct = 6;
				end
			endcase
			repeat (24) send_value(random_value());
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("signed_int_to_decimal_ascii test passed");
		else
			$display("signed_int_to_decimal_ascii test failed");
		$finish;
	end

endmodule
